// File: hw/rtl/psm_pkg.sv
// ============================================================================
// psm_pkg
// Shared types, constants and helper functions of the Pauli string
// multiplier.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package psm_pkg;

    // Width of one packed string word and of the phase exponent.
    localparam int WORD_W  = 64;
    localparam int PHASE_W = 2;

    // Number of qubits (bit pairs) in one full word.
    localparam int QUBITS = WORD_W / 2;

    // Bits of the header word that carry the phase exponent.
    localparam int HDR_W = 2;

    // Result stream data: product word and phase, padded to whole bytes.
    localparam int M_TDATA_W = ((WORD_W + PHASE_W + 7) / 8) * 8;

    // Mask of the even (X part) bit of every qubit.
    localparam logic [WORD_W-1:0] EVEN_BITS = 64'h5555_5555_5555_5555;

    // Default number of entries in the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Width of a full population count over one qubit mask.
    localparam int POP_W = $clog2(QUBITS + 1);

    // One classified word pair as it travels from front to back.
    typedef struct packed {
        logic [WORD_W-1:0]  product;
        logic [PHASE_W-1:0] phase_inc;
        logic               last;
    } psm_work_t;

    // Population count of a 32-bit mask as a shallow two-level adder tree:
    // eight independent nibble counts, then a short sum of those.
    function automatic logic [POP_W-1:0] popcount32(input logic [QUBITS-1:0] v);
        logic [2:0]       nib [QUBITS/4];
        logic [POP_W-1:0] total;
        for (int i = 0; i < QUBITS / 4; i++)
        begin
            nib[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
        end
        total = '0;
        for (int i = 0; i < QUBITS / 4; i++)
        begin
            total = total + POP_W'(nib[i]);
        end
        return total;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/psm_front.sv
// ============================================================================
// psm_front
// Front stage: takes in word pairs, tells header words from body words,
// forms the XOR product and the word's phase increment, and registers them.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module psm_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [psm_pkg::WORD_W-1:0]  left_word,
    input  wire logic [psm_pkg::WORD_W-1:0]  right_word,
    input  wire logic                        last_word,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output psm_pkg::psm_work_t               out_work
);

    logic                       at_first_reg;
    logic                       at_first_next;
    logic                       stage_valid_reg;
    logic                       stage_valid_next;
    psm_pkg::psm_work_t         work_reg;
    psm_pkg::psm_work_t         work_next;
    logic                       take;

    logic [psm_pkg::WORD_W-1:0]  x;
    logic [psm_pkg::WORD_W-1:0]  y;
    logic [psm_pkg::WORD_W-1:0]  p;
    logic [psm_pkg::WORD_W-1:0]  xs;
    logic [psm_pkg::WORD_W-1:0]  ys;
    logic [psm_pkg::WORD_W-1:0]  ps;
    logic [psm_pkg::WORD_W-1:0]  busy;
    logic [psm_pkg::WORD_W-1:0]  flip;
    logic [psm_pkg::QUBITS-1:0]  busy_q;
    logic [psm_pkg::QUBITS-1:0]  flip_q;
    logic [psm_pkg::POP_W-1:0]   busy_cnt;
    logic [psm_pkg::PHASE_W-1:0] hdr_phase;

    // The stage takes a new pair when it is empty or drains in this cycle.
    assign in_ready = !stage_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // Header words lose their phase bits before the qubit product.
    always_comb
    begin
        if (at_first_reg)
        begin
            x         = left_word >> psm_pkg::HDR_W;
            y         = right_word >> psm_pkg::HDR_W;
            hdr_phase = left_word[psm_pkg::PHASE_W-1:0] + right_word[psm_pkg::PHASE_W-1:0];
        end
        else
        begin
            x         = left_word;
            y         = right_word;
            hdr_phase = '0;
        end
    end

    // Qubits that are non-identity in both operands and the product, and
    // among them those that give the opposite sign.
    assign p    = x ^ y;
    assign xs   = x >> 1;
    assign ys   = y >> 1;
    assign ps   = p >> 1;
    assign busy = (x | xs) & (y | ys) & (p | ps) & psm_pkg::EVEN_BITS;
    assign flip = ((xs & y) ^ (p & ps)) & busy;

    // Both masks live on even bits only; gather them into one bit per qubit.
    always_comb
    begin
        for (int i = 0; i < psm_pkg::QUBITS; i++)
        begin
            busy_q[i] = busy[2*i];
            flip_q[i] = flip[2*i];
        end
    end

    assign busy_cnt = psm_pkg::popcount32(busy_q);

    // Phase increment mod 4: popcount(busy) + 2 * parity(flip) + header phases.
    always_comb
    begin
        work_next.product   = at_first_reg ? (p << psm_pkg::HDR_W) : p;
        work_next.phase_inc = busy_cnt[psm_pkg::PHASE_W-1:0]
                            + {^flip_q, 1'b0}
                            + hdr_phase;
        work_next.last      = last_word;
    end

    // Control next-state logic.
    always_comb
    begin
        at_first_next    = at_first_reg;
        stage_valid_next = stage_valid_reg;
        if (take)
        begin
            at_first_next    = last_word;
            stage_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_first_reg    <= 1'b1;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            at_first_reg    <= at_first_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            work_reg <= work_next;
        end
    end

    assign out_valid = stage_valid_reg;
    assign out_work  = work_reg;

endmodule

`default_nettype wire

// File: hw/rtl/psm_queue.sv
// ============================================================================
// psm_queue
// Short first-in first-out queue of classified word pairs that lets the
// front and back stages stall independently.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module psm_queue #(
    // Number of entries; a power of two, at least 2.
    parameter int DEPTH = psm_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  psm_pkg::psm_work_t      in_work,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output psm_pkg::psm_work_t      out_work
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    psm_pkg::psm_work_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_work  = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates; pointers wrap at the power-of-two depth.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_work;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/psm_back.sv
// ============================================================================
// psm_back
// Back stage: accumulates the phase exponent over a string and holds the
// result word in the output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module psm_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  psm_pkg::psm_work_t                in_work,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [psm_pkg::WORD_W-1:0]        product_word,
    output logic                              end_of_string,
    output logic [psm_pkg::PHASE_W-1:0]       final_phase
);

    logic [psm_pkg::PHASE_W-1:0] phase_sum_reg;
    logic [psm_pkg::PHASE_W-1:0] phase_sum_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [psm_pkg::WORD_W-1:0]  product_reg;
    logic                        last_reg;
    logic [psm_pkg::PHASE_W-1:0] phase_out_reg;
    logic [psm_pkg::PHASE_W-1:0] sum;
    logic                        take;

    // The output register reloads when empty or when its result is taken.
    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // The running sum is zero at every header, so no first-word flag is needed.
    assign sum = phase_sum_reg + in_work.phase_inc;

    always_comb
    begin
        phase_sum_next = phase_sum_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            phase_sum_next = in_work.last ? '0 : sum;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_sum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_sum_reg <= phase_sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            product_reg   <= in_work.product;
            last_reg      <= in_work.last;
            phase_out_reg <= in_work.last ? sum : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign product_word  = product_reg;
    assign end_of_string = last_reg;
    assign final_phase   = phase_out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/pauli_string_multiply.sv
// ============================================================================
// pauli_string_multiply
// Streaming multiplier of two packed Pauli strings with phase tracking.
// ============================================================================
// The block takes one word pair of two Pauli strings per cycle and returns
// one product word per pair, at a sustained rate of one pair per clock while
// the output is not stalled. Each result passes through the front register,
// one queue entry and the output register. The first pair of a
// string is its header: bits 1:0 of both words carry phase exponents, and
// its product word comes back with bits 1:0 cleared. The pair marked with
// tlast closes the string; its result carries tlast and the accumulated
// phase exponent mod 4 in bits 65:64 of tdata, which the host ORs into the
// first product word. Those bits are zero on all other results. The next
// pair after a tlast transfer starts a new string with a header.
`timescale 1ns / 1ps
`default_nettype none

module pauli_string_multiply #(
    // Entries in the queue between front and back; a power of two, >= 2.
    parameter int QUEUE_DEPTH = psm_pkg::QUEUE_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: left_word[63:0], right_word[63:0].
    input  wire logic [2*psm_pkg::WORD_W-1:0]    s_axis_tdata,
    // last_word.
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // Fields from bit 0: product_word[63:0], final_phase[65:64], zeros above.
    output logic [psm_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    // end_of_string.
    output logic                                 m_axis_tlast
);

    logic                          front_valid;
    logic                          q_in_ready;
    psm_pkg::psm_work_t            front_work;
    logic                          q_out_valid;
    logic                          back_ready;
    psm_pkg::psm_work_t            q_work;
    logic [psm_pkg::WORD_W-1:0]    back_product;
    logic [psm_pkg::PHASE_W-1:0]   back_phase;

    // Front stage: classify each pair and form its product and phase step.
    psm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .left_word  (s_axis_tdata[psm_pkg::WORD_W-1:0]),
        .right_word (s_axis_tdata[2*psm_pkg::WORD_W-1:psm_pkg::WORD_W]),
        .last_word  (s_axis_tlast),
        .out_valid  (front_valid),
        .out_ready  (q_in_ready),
        .out_work   (front_work)
    );

    // Queue between the two stages.
    psm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (q_in_ready),
        .in_work   (front_work),
        .out_valid (q_out_valid),
        .out_ready (back_ready),
        .out_work  (q_work)
    );

    // Back stage: phase accumulation and output register.
    psm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (q_out_valid),
        .in_ready      (back_ready),
        .in_work       (q_work),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .product_word  (back_product),
        .end_of_string (m_axis_tlast),
        .final_phase   (back_phase)
    );

    // Pack the result fields into the output data bus, zero padded.
    assign m_axis_tdata = psm_pkg::M_TDATA_W'({back_phase, back_product});

    // The phase is reported only on the result that closes a string.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (back_phase == '0))
    else $error("Phase reported on a result that does not close a string.");

    // A queue that refuses entries must be offering one to the back stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        !q_in_ready |-> q_out_valid)
    else $error("Queue reports full while holding no entry.");

    // A result can only appear after the queue offered an entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(q_out_valid))
    else $error("Result appeared without a queued word pair.");

    // A stalled input side means the front register is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (front_valid && !q_in_ready))
    else $error("Input stalled while the front stage could advance.");

endmodule

`default_nettype wire

// File: bench/tb_pauli_string_multiply.sv
// ============================================================================
// tb_pauli_string_multiply
// Self-checking bench for the streaming Pauli string multiplier.
// ============================================================================
// Word pairs of two Pauli strings are pushed through the slave stream, and
// product words are pulled from the master stream. A predictor in the
// scoreboard works out each product word and the closing phase exponent from
// every accepted pair. Each result is then compared in order with what was
// predicted. A short directed pass covers header phases, single-word strings
// and the extreme bit patterns. Random strings of varying length follow, and
// both sides of the block idle at random. In one long hold-off the output
// side stays stalled while pairs go in gap-free; the block backs up onto its input.
`timescale 1ns / 1ps

module tb_pauli_string_multiply;

    localparam int RANDOM_PAIRS  = 1750;
    localparam int SQUEEZE_AFTER = 300;
    localparam int SQUEEZE_LEN   = 200;
    localparam int DRAIN_CYCLES  = 20;

    // Qubit patterns across a whole word: X on every even bit, Z on every odd bit.
    localparam logic [psm_pkg::WORD_W-1:0] ALL_X = 64'h5555_5555_5555_5555;
    localparam logic [psm_pkg::WORD_W-1:0] ALL_Z = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [psm_pkg::WORD_W-1:0] ALL_Y = 64'hFFFF_FFFF_FFFF_FFFF;

    // One expected product as it leaves the block.
    typedef struct packed {
        logic [psm_pkg::WORD_W-1:0]  word;
        logic                        last;
        logic [psm_pkg::PHASE_W-1:0] phase;
    } product_t;

    // Predicts the product stream and checks what the block returns.
    class product_scoreboard;
        product_t                    expected_q[$];
        bit                          header_next;
        logic [psm_pkg::PHASE_W-1:0] running_phase;
        int                          errors;

        function new();
            header_next   = 1'b1;
            running_phase = '0;
            errors        = 0;
        endfunction

        // XOR product of two qubit fields and its phase contribution mod 4.
        function logic [psm_pkg::PHASE_W-1:0] qubit_product(
                input logic [psm_pkg::WORD_W-1:0] x,
                input logic [psm_pkg::WORD_W-1:0] y,
                output logic [psm_pkg::WORD_W-1:0] prod);
            logic [psm_pkg::WORD_W-1:0] busy;
            logic [psm_pkg::WORD_W-1:0] flip;
            int                         count;
            prod  = x ^ y;
            busy  = (x | (x >> 1)) & (y | (y >> 1)) & (prod | (prod >> 1)) & ALL_X;
            flip  = (((x >> 1) & y) ^ (prod & (prod >> 1))) & busy;
            count = 2 * $countones(flip) + $countones(busy);
            return count[psm_pkg::PHASE_W-1:0];
        endfunction

        // A pair has been taken by the block: predict its product word.
        function void note_pair(input logic [psm_pkg::WORD_W-1:0] left,
                                input logic [psm_pkg::WORD_W-1:0] right,
                                input logic last);
            logic [psm_pkg::WORD_W-1:0]  prod;
            logic [psm_pkg::PHASE_W-1:0] sum;
            product_t                    res;
            if (header_next)
            begin
                sum  = left[psm_pkg::HDR_W-1:0] + right[psm_pkg::HDR_W-1:0];
                sum  = sum + qubit_product(left >> psm_pkg::HDR_W,
                                           right >> psm_pkg::HDR_W, prod);
                prod = prod << psm_pkg::HDR_W;
            end
            else
            begin
                sum = running_phase + qubit_product(left, right, prod);
            end
            res.word  = prod;
            res.last  = last;
            res.phase = last ? sum : '0;
            expected_q.push_back(res);
            // A closing pair returns the phase tracker to its idle state.
            header_next   = last;
            running_phase = last ? '0 : sum;
        endfunction

        // A product word has left the block: compare with the oldest prediction.
        function void check_result(input logic [psm_pkg::WORD_W-1:0] word,
                                   input logic last,
                                   input logic [psm_pkg::PHASE_W-1:0] phase);
            product_t exp_res;
            if (expected_q.size() == 0)
            begin
                $error("unexpected product transfer: word %h last %0d phase %0d",
                       word, last, phase);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (word !== exp_res.word)
            begin
                $error("product_word mismatch: expected %h, actual %h", exp_res.word, word);
                errors++;
            end
            if (last !== exp_res.last)
            begin
                $error("end_of_string mismatch: expected %0d, actual %0d", exp_res.last, last);
                errors++;
            end
            if (phase !== exp_res.phase)
            begin
                $error("final_phase mismatch: expected %0d, actual %0d", exp_res.phase, phase);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                                 clk;
    logic                                 rst_n;
    logic                                 s_axis_tvalid;
    logic                                 s_axis_tready;
    logic [2*psm_pkg::WORD_W-1:0]         s_axis_tdata;
    logic                                 s_axis_tlast;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready;
    logic [psm_pkg::M_TDATA_W-1:0]        m_axis_tdata;
    logic                                 m_axis_tlast;

    product_scoreboard sb;
    int  products_taken;
    bit  squeeze_on;
    bit  squeeze_done;

    pauli_string_multiply dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock with a 10 ns period.
    always #5 clk = ~clk;

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Random string word with a mix of dense, sparse and uniform qubit patterns.
    function automatic logic [psm_pkg::WORD_W-1:0] pick_word();
        logic [psm_pkg::WORD_W-1:0] a;
        logic [psm_pkg::WORD_W-1:0] b;
        logic [psm_pkg::WORD_W-1:0] pattern;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: pattern = '0;
            1: pattern = ALL_X;
            2: pattern = ALL_Z;
            default: pattern = ALL_Y;
        endcase
        case ($urandom_range(0, 5))
            0, 1: return a;
            2: return a & b;
            3: return a | b;
            4: return pattern;
            default: return pattern & a;
        endcase
    endfunction

    // Offer one word pair after an optional idle stretch and wait for its transfer.
    task automatic send_pair(input logic [psm_pkg::WORD_W-1:0] left,
                             input logic [psm_pkg::WORD_W-1:0] right,
                             input logic last, input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right, left};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_pair(left, right, last);
        @(negedge clk);
    endtask

    // Stimulus: directed strings, then random strings, then drain and report.
    initial
    begin
        logic [3:0] ph;
        int         sent;
        int         len;
        bit         quiet;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        sb            = new();
        products_taken = 0;
        squeeze_on    = 1'b0;
        squeeze_done  = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Single-word strings carrying every pair of header phases.
        for (int i = 0; i < 16; i++)
        begin
            ph = i[3:0];
            send_pair((pick_word() << psm_pkg::HDR_W) | 64'(ph[1:0]),
                      (pick_word() << psm_pkg::HDR_W) | 64'(ph[3:2]), 1'b1, 0);
        end

        // Extreme bit patterns as single-word strings.
        send_pair('0, '0, 1'b1, 0);
        send_pair(ALL_Y, ALL_Y, 1'b1, 1);
        send_pair(ALL_Y, '0, 1'b1, 0);

        // A three-word string: X times Z in the header, then Y against I, then Z times Y.
        send_pair(ALL_X, ALL_Z | 64'h1, 1'b0, 0);
        send_pair(ALL_Y, '0, 1'b0, 2);
        send_pair(ALL_Z, ALL_Y, 1'b1, 0);

        // Random strings, mostly short, with a few long ones.
        sent = 0;
        while (sent < RANDOM_PAIRS)
        begin
            if ($urandom_range(0, 4) == 0)
                len = 1;
            else if ($urandom_range(0, 19) == 0)
                len = $urandom_range(16, 24);
            else
                len = $urandom_range(2, 8);
            quiet = ($urandom_range(0, 3) == 0);
            for (int w = 0; w < len; w++)
            begin
                send_pair(pick_word(), pick_word(), w == len - 1,
                          (quiet || squeeze_on) ? 0 : pick_gap());
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // Wait for every predicted product, then keep watching for strays before reporting.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[pauli_string_multiply] OK");
        else
            $display("[pauli_string_multiply] ERROR");
        $finish;
    end

    // Output side: random back-pressure plus one long hold-off to fill the block.
    initial
    begin
        int  hold_left;
        int  cyc;
        bit  quiet;
        m_axis_tready = 1'b0;
        hold_left     = 0;
        cyc           = 0;
        quiet         = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!squeeze_done && products_taken >= SQUEEZE_AFTER)
            begin
                squeeze_on = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (SQUEEZE_LEN) @(negedge clk);
                squeeze_on   = 1'b0;
                squeeze_done = 1'b1;
            end
            cyc++;
            if (cyc % 128 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!quiet)
                    hold_left = pick_gap();
            end
        end
    end

    // Check every product transfer at the clock edge that completes it.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata[psm_pkg::WORD_W-1:0], m_axis_tlast,
                            m_axis_tdata[psm_pkg::WORD_W+psm_pkg::PHASE_W-1:psm_pkg::WORD_W]);
            products_taken++;
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #20_000_000;
        $display("[pauli_string_multiply] ERROR");
        $finish;
    end

endmodule
